@@ src/pil_pkg.sv @@
// Shared types and codes for the position indexed list unit.
package pil_pkg;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_GET    = 3'd2,
    ACT_LOCATE = 3'd3,
    ACT_CLEAR  = 3'd4
  } pil_action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } pil_status_e;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned PosWidth   = 5;

  // Per-cell update controls for one cycle.
  typedef struct packed {
    logic load;        // take the incoming word
    logic take_left;   // take the word of the lower neighbor
    logic take_right;  // take the word of the upper neighbor
  } pil_cell_ctrl_t;

endpackage

@@ src/pil_cell.sv @@
// One storage cell of the list: holds one word, shifts and compares.
module pil_cell (
  input  logic                                clk_i,
  input  pil_pkg::pil_cell_ctrl_t             ctrl_i,
  input  logic signed [pil_pkg::DataWidth-1:0] value_i,
  input  logic signed [pil_pkg::DataWidth-1:0] left_i,
  input  logic signed [pil_pkg::DataWidth-1:0] right_i,
  input  logic                                valid_i,
  input  logic                                seen_i,
  output logic                                seen_o,
  output logic                                first_o,
  output logic signed [pil_pkg::DataWidth-1:0] data_o
);
  import pil_pkg::*;

  logic signed [DataWidth-1:0] data_q, data_d;
  logic                        hit;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = value_i;
    end else if (ctrl_i.take_left) begin
      data_d = left_i;
    end else if (ctrl_i.take_right) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // The match token runs up the chain so that only the lowest hit reports.
  assign hit     = valid_i && (data_q == value_i);
  assign first_o = hit && !seen_i;
  assign seen_o  = hit || seen_i;
  assign data_o  = data_q;

endmodule

@@ src/position_indexed_list_unit.sv @@
// Top level of the position indexed list unit: control and a row of cells.
//
// Usage: a command word (action, position, value) is taken at a rising edge
// where start_i is high and busy_o is low. busy_o stays low, so a new command
// may be issued in every cycle. In the cycle after a command is taken, done_o is
// high for exactly one cycle and the result word (status, read value, found
// position and list length) is valid on the result ports in that cycle.
// The throughput is one command per cycle: every
// cell of the chain shifts, loads or compares in parallel, and the locate
// result is found by a first-match token that ripples through the chain in
// the same cycle.
// Positions are 1-based. Insert moves the upper part of the list one cell up,
// delete moves it one cell down; get reads one cell through an OR-select.
// Reset clears the element count and the result strobe; cell contents are not
// cleared and are only read once an insert has written them.
// The receiver cannot stall: a result is shown for its one cycle only, and
// the caller must take it then.
module position_indexed_list_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [2:0]                           action_i,
  input  logic [pil_pkg::PosWidth-1:0]         position_i,
  input  logic signed [pil_pkg::DataWidth-1:0] value_i,
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic signed [pil_pkg::DataWidth-1:0] read_value_o,
  output logic [pil_pkg::PosWidth-1:0]         found_position_o,
  output logic [pil_pkg::PosWidth-1:0]         elem_count_o
);
  import pil_pkg::*;

  // Width of the element count, which must hold CAPACITY itself.
  localparam int unsigned CntWidth = $clog2(CAPACITY + 1);
  // Common compare width for positions, counts and cell indexes.
  localparam int unsigned CmpWidth =
    ((CntWidth > PosWidth) ? CntWidth : PosWidth) + 1;

  logic [CntWidth-1:0] fill_q, fill_d;
  logic                done_q;
  pil_status_e         status_q, status_d;
  logic signed [DataWidth-1:0] rdval_q, rdval_d;
  logic [PosWidth-1:0] found_q, found_d;
  logic [PosWidth-1:0] length_q;

  logic                accept;
  logic [CmpWidth-1:0] pos_ext, fill_ext;
  logic                pos_ins_ok, pos_acc_ok, room_ok;
  logic                do_insert, do_delete;

  pil_cell_ctrl_t              cell_ctrl [CAPACITY];
  logic signed [DataWidth-1:0] cell_data [CAPACITY];
  logic                        cell_valid[CAPACITY];
  logic                        cell_first[CAPACITY];
  logic                        seen_chain[CAPACITY+1];

  assign accept   = start_i && !busy_o;
  assign busy_o   = 1'b0;
  assign pos_ext  = CmpWidth'(position_i);
  assign fill_ext = CmpWidth'(fill_q);

  assign pos_ins_ok = (pos_ext != '0) && (pos_ext <= fill_ext + CmpWidth'(1));
  assign pos_acc_ok = (pos_ext != '0) && (pos_ext <= fill_ext);
  assign room_ok    = (fill_ext < CmpWidth'(CAPACITY));

  assign do_insert = accept && (pil_action_e'(action_i) == ACT_INSERT)
                     && pos_ins_ok && room_ok;
  assign do_delete = accept && (pil_action_e'(action_i) == ACT_DELETE)
                     && pos_acc_ok;

  // Per-cell controls: cell k holds list position k+1.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cell_ctrl[k].load       = do_insert && (CmpWidth'(k) + CmpWidth'(1) == pos_ext);
      cell_ctrl[k].take_left  = do_insert && (CmpWidth'(k) + CmpWidth'(1) > pos_ext)
                                && (CmpWidth'(k) <= fill_ext);
      cell_ctrl[k].take_right = do_delete && (CmpWidth'(k) + CmpWidth'(1) >= pos_ext)
                                && (CmpWidth'(k) + CmpWidth'(1) < fill_ext);
      cell_valid[k]           = CmpWidth'(k) < fill_ext;
    end
  end

  assign seen_chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    pil_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[g]),
      .value_i (value_i),
      .left_i  ((g == 0) ? value_i : cell_data[(g == 0) ? 0 : g - 1]),
      .right_i ((g == CAPACITY - 1) ? cell_data[g]
                                    : cell_data[(g == CAPACITY - 1) ? g : g + 1]),
      .valid_i (cell_valid[g]),
      .seen_i  (seen_chain[g]),
      .seen_o  (seen_chain[g+1]),
      .first_o (cell_first[g]),
      .data_o  (cell_data[g])
    );
  end

  // Result word and the new element count.
  always_comb begin
    logic signed [DataWidth-1:0] sel_data;
    logic [CmpWidth-1:0]         hit_pos;
    sel_data = '0;
    hit_pos  = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (CmpWidth'(k) + CmpWidth'(1) == pos_ext) begin
        sel_data = sel_data | cell_data[k];
      end
      if (cell_first[k]) begin
        hit_pos = hit_pos | (CmpWidth'(k) + CmpWidth'(1));
      end
    end

    fill_d   = fill_q;
    status_d = ST_OK;
    rdval_d  = '0;
    found_d  = '0;
    case (pil_action_e'(action_i))
      ACT_INSERT: begin
        if (!pos_ins_ok) begin
          status_d = ST_BADPOS;
        end else if (!room_ok) begin
          status_d = ST_FULL;
        end else begin
          fill_d = fill_q + CntWidth'(1);
        end
      end
      ACT_DELETE: begin
        if (!pos_acc_ok) begin
          status_d = ST_BADPOS;
        end else begin
          fill_d = fill_q - CntWidth'(1);
        end
      end
      ACT_GET: begin
        if (!pos_acc_ok) begin
          status_d = ST_BADPOS;
        end else begin
          rdval_d = sel_data;
        end
      end
      ACT_LOCATE: begin
        if (seen_chain[CAPACITY]) begin
          found_d = PosWidth'(hit_pos);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      ACT_CLEAR: begin
        fill_d = '0;
      end
      default: begin
        fill_d = fill_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdval_q  <= rdval_d;
      found_q  <= found_d;
      length_q <= PosWidth'(fill_d);
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign read_value_o     = rdval_q;
  assign found_position_o = found_q;
  assign elem_count_o     = length_q;

`ifndef SYNTHESIS
  // The element count never exceeds the number of cells.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntWidth'(CAPACITY))
    else $error("element count above capacity");

  // Every accepted command yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted command without result");

  // A failed command leaves the element count as it was.
  a_error_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> $stable(fill_q))
    else $error("failed command changed the list length");

  // A locate miss reports no position.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NOTFOUND)) |-> (found_position_o == '0))
    else $error("locate miss with a nonzero position");
`endif

endmodule

@@ bench/position_indexed_list_unit_test.sv @@
// Self-checking testbench for the position indexed list unit.
`timescale 1ns / 1ps

module position_indexed_list_unit_test;
  import pil_pkg::*;

  localparam int unsigned CAPACITY = 16;
  // The result word comes in the cycle after its command word.
  localparam int RESULT_LATENCY = 1;
  localparam int RANDOM_BLOCKS = 20;
  localparam int BLOCK_WORDS = 50;

  // One command word as the driver presents it, plus its pacing. The idle
  // count is the gap the sender leaves before it, and the drain flag holds
  // the word back until every outstanding result word has come.
  typedef struct packed {
    logic [2:0]                   action;
    logic [PosWidth-1:0]          position;
    logic signed [DataWidth-1:0]  value;
    logic [2:0]                   idle_before;
    logic                         drain_first;
  } list_command_t;

  typedef struct packed {
    pil_status_e                  status;
    logic signed [DataWidth-1:0]  read_value;
    logic [PosWidth-1:0]          found_position;
    logic [PosWidth-1:0]          elem_count;
  } list_result_t;

  // Random traffic runs in blocks, each one leaning toward filling the list,
  // emptying it, or a balanced mix.
  typedef enum int {GROW_PHASE, SHRINK_PHASE, MIXED_PHASE} list_trend_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start_i = 1'b0;
  logic [2:0]                   action_i = 3'b000;
  logic [PosWidth-1:0]          position_i = '0;
  logic signed [DataWidth-1:0]  value_i = '0;
  logic                         busy_o;
  logic                         done_o;
  logic [1:0]                   status_o;
  logic signed [DataWidth-1:0]  read_value_o;
  logic [PosWidth-1:0]          found_position_o;
  logic [PosWidth-1:0]          elem_count_o;

  position_indexed_list_unit #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .found_position_o(found_position_o),
    .elem_count_o    (elem_count_o)
  );

  list_command_t pending_q[$];
  list_result_t  expected_q[$];

  // Counters are updated with nonblocking assignments, so the driver and the
  // end-of-run logic always see the values from before the current edge.
  int unsigned accepted_count = 0;
  int unsigned result_count = 0;
  int unsigned failures = 0;

  // The predicted contents of the list, updated as each command is taken.
  logic signed [DataWidth-1:0] list_elems[CAPACITY];
  int unsigned list_len = 0;

  // A cheap length-only shadow used while planning stimulus, so that most
  // random positions land inside the list.
  int unsigned planned_len = 0;
  logic signed [DataWidth-1:0] value_pool[8];

  // Driver bookkeeping for the word at the front of the pending queue.
  bit primed = 1'b0;
  int idle_left = 0;
  bit hold_for_drain = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Applies one command to the predicted list and returns the result word it
  // must produce.
  function automatic list_result_t apply_list_command(input list_command_t c);
    list_result_t r;
    int unsigned p;
    r.status = ST_OK;
    r.read_value = '0;
    r.found_position = '0;
    p = c.position;
    case (c.action)
      ACT_INSERT: begin
        // The position check wins over the capacity check.
        if (p < 1 || p > list_len + 1) begin
          r.status = ST_BADPOS;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = list_len; k > p - 1; k--) list_elems[k] = list_elems[k - 1];
          list_elems[p - 1] = c.value;
          list_len++;
        end
      end
      ACT_DELETE: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int k = p - 1; k + 1 < list_len; k++) list_elems[k] = list_elems[k + 1];
          list_len--;
        end
      end
      ACT_GET: begin
        if (p < 1 || p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_value = list_elems[p - 1];
        end
      end
      ACT_LOCATE: begin
        // Only the first match counts; an empty list always misses.
        r.status = ST_NOTFOUND;
        for (int k = 0; k < list_len; k++) begin
          if (r.status == ST_NOTFOUND && list_elems[k] == c.value) begin
            r.status = ST_OK;
            r.found_position = PosWidth'(k + 1);
          end
        end
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      default: begin
        // Unused action codes change nothing and report ok.
      end
    endcase
    r.elem_count = PosWidth'(list_len);
    return r;
  endfunction

  // Appends a command word to the pending queue and tracks the list length
  // that it will leave behind.
  task automatic queue_command(input int a, input int p, input logic signed [31:0] v,
                               input int idle, input bit drain);
    list_command_t c;
    c.action = 3'(a);
    c.position = PosWidth'(p);
    c.value = v;
    c.idle_before = 3'(idle);
    c.drain_first = drain;
    pending_q.push_back(c);
    if (a == ACT_INSERT && p >= 1 && p <= planned_len + 1 && planned_len < CAPACITY) begin
      planned_len++;
    end else if (a == ACT_DELETE && p >= 1 && p <= planned_len) begin
      planned_len--;
    end else if (a == ACT_CLEAR) begin
      planned_len = 0;
    end
  endtask

  // Plans one random command word. Most words are well formed with a
  // position inside the list; the rest are noise over the whole field space,
  // unused action codes included.
  task automatic plan_random_command(input list_trend_e trend, input int idle_pct,
                                     input bit drain);
    int roll;
    int ins_w;
    int del_w;
    int a;
    int p;
    int lim;
    int idle;
    logic signed [31:0] v;
    v = $urandom_range(1) ? value_pool[$urandom_range(7)] : $urandom;
    idle = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    case (trend)
      GROW_PHASE: begin
        ins_w = 60;
        del_w = 12;
      end
      SHRINK_PHASE: begin
        ins_w = 15;
        del_w = 55;
      end
      default: begin
        ins_w = 35;
        del_w = 30;
      end
    endcase
    roll = $urandom_range(99);
    if (roll < 8) begin
      a = $urandom_range(7);
      p = $urandom_range(31);
    end else begin
      roll = $urandom_range(99);
      if (roll < ins_w) a = ACT_INSERT;
      else if (roll < ins_w + del_w) a = ACT_DELETE;
      else if (roll < 84) a = ACT_GET;
      else if (roll < 98) a = ACT_LOCATE;
      else a = ACT_CLEAR;
      lim = (a == ACT_INSERT) ? planned_len + 1 : planned_len;
      if (lim == 0 || $urandom_range(9) == 0) p = $urandom_range(31);
      else p = $urandom_range(1, lim);
    end
    queue_command(a, p, v, idle, drain);
  endtask

  // Driver: presents the front of the pending queue and keeps it there until
  // the block takes it. Idle gaps and drain holds come between words.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      primed = 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        pending_q.delete(0);
        primed = 1'b0;
      end
      if (!primed && pending_q.size() > 0) begin
        idle_left = pending_q[0].idle_before;
        hold_for_drain = pending_q[0].drain_first;
        primed = 1'b1;
      end
      if (!primed) begin
        start_i <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        start_i <= 1'b0;
      end else if (hold_for_drain && (start_i || accepted_count != result_count)) begin
        // The counters are only trusted once start has been low for a cycle,
        // so the last word taken is already counted.
        start_i <= 1'b0;
      end else begin
        hold_for_drain = 1'b0;
        start_i <= 1'b1;
        action_i <= pending_q[0].action;
        position_i <= pending_q[0].position;
        value_i <= pending_q[0].value;
      end
    end
  end

  // Monitor: checks the result word that ends this cycle, then records the
  // command word taken at this edge. As the result word is registered, a
  // result never belongs to the command taken at the same edge.
  always @(posedge clk_i) begin
    list_result_t want;
    list_command_t taken;
    if (rst_ni) begin
      if (done_o) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          failures++;
          $display("%0t: result word with none expected, actual status %0d length %0d",
                   $time, status_o, elem_count_o);
        end else begin
          want = expected_q.pop_front();
          if (status_o !== want.status) begin
            failures++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_o);
          end
          if (read_value_o !== want.read_value) begin
            failures++;
            $display("%0t: read value mismatch, expected %0d, actual %0d",
                     $time, want.read_value, read_value_o);
          end
          if (found_position_o !== want.found_position) begin
            failures++;
            $display("%0t: found position mismatch, expected %0d, actual %0d",
                     $time, want.found_position, found_position_o);
          end
          if (elem_count_o !== want.elem_count) begin
            failures++;
            $display("%0t: list length mismatch, expected %0d, actual %0d",
                     $time, want.elem_count, elem_count_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        taken.action = action_i;
        taken.position = position_i;
        taken.value = value_i;
        taken.idle_before = '0;
        taken.drain_first = 1'b0;
        expected_q.push_back(apply_list_command(taken));
        accepted_count <= accepted_count + 1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    list_trend_e trend;
    int idle_pct;
    value_pool[0] = 32'sh7fffffff;
    value_pool[1] = 32'sh80000000;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

    // Directed words. Unused action codes on an empty list, with every
    // position and value bit high.
    for (int c = ACT_CLEAR + 1; c < 8; c++) queue_command(c, 31, -1, 0, 1'b0);
    // Empty list: every position is bad and locate always misses.
    queue_command(ACT_GET, 1, 0, 0, 1'b0);
    queue_command(ACT_DELETE, 0, 0, 0, 1'b0);
    queue_command(ACT_LOCATE, 0, 0, 0, 1'b0);
    queue_command(ACT_INSERT, 0, 5, 0, 1'b0);
    queue_command(ACT_INSERT, 2, 5, 0, 1'b0);
    // Inserts at the front, the end and the middle, with extreme values.
    queue_command(ACT_INSERT, 1, 32'sh7fffffff, 0, 1'b0);
    queue_command(ACT_INSERT, 1, 32'sh80000000, 2, 1'b0);
    queue_command(ACT_INSERT, 3, 0, 0, 1'b0);
    queue_command(ACT_INSERT, 2, -1, 0, 1'b0);
    // Reads just past both ends, at the end and far past it, and a hit and a miss on locate.
    queue_command(ACT_GET, 0, 0, 0, 1'b0);
    queue_command(ACT_GET, 31, 0, 0, 1'b0);
    queue_command(ACT_GET, 4, 0, 0, 1'b0);
    queue_command(ACT_GET, 5, 0, 0, 1'b0);
    queue_command(ACT_LOCATE, 7, 32'sh80000000, 0, 1'b0);
    queue_command(ACT_LOCATE, 0, 12345, 0, 1'b0);
    // Deletes past the end, in the middle and at the end.
    queue_command(ACT_DELETE, 5, 0, 0, 1'b0);
    queue_command(ACT_DELETE, 2, 0, 0, 1'b0);
    queue_command(ACT_DELETE, 3, 0, 0, 1'b0);
    // After a clear the old entries keep their bits but must not be seen.
    queue_command(ACT_CLEAR, 9, 77, 0, 1'b0);
    queue_command(ACT_GET, 1, 0, 0, 1'b0);
    queue_command(ACT_LOCATE, 0, 32'sh7fffffff, 0, 1'b0);
    // Fill to capacity, then insert at a valid and at a bad position.
    for (int i = 0; i < CAPACITY; i++) queue_command(ACT_INSERT, 1, i * 3 + 1, 0, 1'b0);
    queue_command(ACT_INSERT, CAPACITY + 1, 99, 0, 1'b0);
    queue_command(ACT_INSERT, CAPACITY + 2, 99, 0, 1'b0);
    queue_command(ACT_INSERT, 1, 99, 0, 1'b0);
    queue_command(ACT_LOCATE, 0, 1, 0, 1'b0);
    queue_command(ACT_GET, CAPACITY, 0, 0, 1'b0);

    // Random blocks. The sender drains the block before some of them, and
    // the last blocks run back to back with no idling at all.
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      trend = list_trend_e'(b % 3);
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (b >= RANDOM_BLOCKS - 2) idle_pct = 0;
      for (int i = 0; i < BLOCK_WORDS; i++) begin
        plan_random_command(trend, idle_pct, i == 0 && b % 5 == 0);
      end
    end

    // Reset is held low from the start and let go on a falling edge, away from
    // the edge where the block samples.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_q.size() != 0 || start_i) @(negedge clk_i);
    while (accepted_count > result_count) @(negedge clk_i);
    repeat (RESULT_LATENCY + 3) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      failures++;
      $display("%0t: %0d result words never came", $time, expected_q.size());
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
